// File: rtl/core/ipv4hc_pkg.sv
// shared types and constants of the ipv4 header checker
`timescale 1ns / 1ps
`default_nettype none

package ipv4hc_pkg;

    // verdict codes
    localparam logic [2:0] VERDICT_FORWARD     = 3'd0;
    localparam logic [2:0] VERDICT_BAD_VERSION = 3'd1;
    localparam logic [2:0] VERDICT_SHORT_HDR   = 3'd2;
    localparam logic [2:0] VERDICT_BAD_CSUM    = 3'd3;
    localparam logic [2:0] VERDICT_BAD_LENGTH  = 3'd4;
    localparam logic [2:0] VERDICT_UNHANDLED   = 3'd5;
    localparam logic [2:0] VERDICT_TRUNCATED   = 3'd6;

    localparam logic [3:0]  IP_VERSION = 4'd4;
    localparam logic [3:0]  MIN_IHL    = 4'd5;
    localparam logic [15:0] SUM_GOOD   = 16'hFFFF;

    // register indexes
    localparam logic REG_HANDLER_BOUND     = 1'b0;
    localparam logic REG_ACCEPTED_PROTOCOL = 1'b1;

    typedef struct packed {
        logic [7:0] packet_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  verdict;
        logic [7:0]  protocol_number;
        logic [31:0] source_address;
        logic [31:0] destination_address;
        logic [5:0]  header_bytes;
        logic [15:0] payload_bytes;
    } out_item_t;

    // per-packet record handed from the front to the back
    typedef struct packed {
        logic [3:0]  version;
        logic [3:0]  ihl;
        logic [15:0] sum;
        logic [15:0] count;
        logic        overflow;
        logic [15:0] length;
        logic [7:0]  protocol;
        logic [31:0] src;
        logic [31:0] dst;
    } summary_t;

endpackage

`default_nettype wire

// File: rtl/core/ipv4hc_front.sv
// byte-wise header capture and ones-complement summing
`timescale 1ns / 1ps
`default_nettype none

module ipv4hc_front (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  take,
    input  wire ipv4hc_pkg::in_item_t  item,
    output logic                       summary_push,
    output ipv4hc_pkg::summary_t       summary
);

    logic [15:0] count_reg;
    logic        overflow_reg;
    logic [15:0] sum_reg;
    logic [7:0]  hold_reg;
    logic [3:0]  version_reg;
    logic [3:0]  ihl_reg;
    logic [15:0] length_reg;
    logic [7:0]  protocol_reg;
    logic [31:0] src_reg;
    logic [31:0] dst_reg;

    logic [15:0] count_next;
    logic        overflow_next;
    logic [15:0] sum_next;
    logic [7:0]  hold_next;
    logic [3:0]  version_next;
    logic [3:0]  ihl_next;
    logic [15:0] length_next;
    logic [7:0]  protocol_next;
    logic [31:0] src_next;
    logic [31:0] dst_next;

    logic [15:0] pos;
    logic [7:0]  b;
    logic        in_hdr;
    logic [16:0] raw_sum;

    assign pos = count_reg;
    assign b   = item.packet_byte;

    always_comb
    begin
        version_next  = version_reg;
        ihl_next      = ihl_reg;
        length_next   = length_reg;
        protocol_next = protocol_reg;
        src_next      = src_reg;
        dst_next      = dst_reg;
        hold_next     = hold_reg;
        sum_next      = sum_reg;

        // fixed-offset field capture
        if (pos == 16'd0)
        begin
            version_next = b[7:4];
            ihl_next     = b[3:0];
        end
        if (pos == 16'd2)
            length_next[15:8] = b;
        if (pos == 16'd3)
            length_next[7:0] = b;
        if (pos == 16'd9)
            protocol_next = b;
        if (pos[15:2] == 14'd3)
        begin
            unique case (pos[1:0])
                2'd0:    src_next[31:24] = b;
                2'd1:    src_next[23:16] = b;
                2'd2:    src_next[15:8]  = b;
                default: src_next[7:0]   = b;
            endcase
        end
        if (pos[15:2] == 14'd4)
        begin
            unique case (pos[1:0])
                2'd0:    dst_next[31:24] = b;
                2'd1:    dst_next[23:16] = b;
                2'd2:    dst_next[15:8]  = b;
                default: dst_next[7:0]   = b;
            endcase
        end

        // checksum span uses the length nibble of this byte at offset zero
        in_hdr  = pos < {10'd0, ihl_next, 2'b00};
        raw_sum = {1'b0, sum_reg} + {1'b0, hold_reg, b};
        if (in_hdr)
        begin
            if (!pos[0])
                hold_next = b;
            else
                sum_next = raw_sum[15:0] + {15'd0, raw_sum[16]};
        end

        // saturating byte count
        if (count_reg == 16'hFFFF)
        begin
            count_next    = count_reg;
            overflow_next = 1'b1;
        end
        else
        begin
            count_next    = count_reg + 16'd1;
            overflow_next = overflow_reg;
        end
    end

    assign summary_push = take && item.last_byte;

    always_comb
    begin
        summary.version  = version_next;
        summary.ihl      = ihl_next;
        summary.sum      = sum_next;
        summary.count    = count_next;
        summary.overflow = overflow_next;
        summary.length   = length_next;
        summary.protocol = protocol_next;
        summary.src      = src_next;
        summary.dst      = dst_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            overflow_reg <= 1'b0;
            sum_reg      <= '0;
            hold_reg     <= '0;
            version_reg  <= '0;
            ihl_reg      <= '0;
            length_reg   <= '0;
            protocol_reg <= '0;
            src_reg      <= '0;
            dst_reg      <= '0;
        end
        else if (take)
        begin
            if (item.last_byte)
            begin
                count_reg    <= '0;
                overflow_reg <= 1'b0;
                sum_reg      <= '0;
                hold_reg     <= '0;
                version_reg  <= '0;
                ihl_reg      <= '0;
                length_reg   <= '0;
                protocol_reg <= '0;
                src_reg      <= '0;
                dst_reg      <= '0;
            end
            else
            begin
                count_reg    <= count_next;
                overflow_reg <= overflow_next;
                sum_reg      <= sum_next;
                hold_reg     <= hold_next;
                version_reg  <= version_next;
                ihl_reg      <= ihl_next;
                length_reg   <= length_next;
                protocol_reg <= protocol_next;
                src_reg      <= src_next;
                dst_reg      <= dst_next;
            end
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/ipv4hc_sum_fifo.sv
// small queue of per-packet records between front and back
`timescale 1ns / 1ps
`default_nettype none

module ipv4hc_sum_fifo #(
    parameter int DEPTH = 2
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  wr_en,
    input  wire ipv4hc_pkg::summary_t  wr_data,
    input  wire logic                  rd_en,
    output ipv4hc_pkg::summary_t       rd_data,
    output logic                       full,
    output logic                       not_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    ipv4hc_pkg::summary_t mem [DEPTH];

    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          do_wr, do_rd;

    assign full      = cnt_reg == FULL_CNT;
    assign not_empty = cnt_reg != '0;
    assign do_wr     = wr_en && !full;
    assign do_rd     = rd_en && not_empty;
    assign rd_data   = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_wr)
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PW'(1);
        if (do_rd)
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PW'(1);
        if (do_wr && !do_rd)
            cnt_next = cnt_reg + CW'(1);
        else if (do_rd && !do_wr)
            cnt_next = cnt_reg - CW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem[wr_ptr_reg] <= wr_data;
    end

endmodule

`default_nettype wire

// File: rtl/core/ipv4hc_back.sv
// verdict evaluation and result register
`timescale 1ns / 1ps
`default_nettype none

module ipv4hc_back (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  summary_valid,
    input  wire ipv4hc_pkg::summary_t  summary,
    output logic                       summary_pop,
    input  wire logic                  handler_bound,
    input  wire logic [7:0]            accepted_protocol,
    output ipv4hc_pkg::out_item_t      result,
    output logic                       empty,
    input  wire logic                  pop
);

    logic                  res_valid_reg;
    ipv4hc_pkg::out_item_t res_reg;
    ipv4hc_pkg::out_item_t res_next;

    logic [5:0]  hdr_bytes;
    logic [15:0] hdr16;
    logic        short_pkt;
    logic [2:0]  verdict;

    assign hdr_bytes = {summary.ihl, 2'b00};
    assign hdr16     = {10'd0, hdr_bytes};
    assign short_pkt = summary.count < hdr16;

    always_comb
    begin
        priority if (summary.version != ipv4hc_pkg::IP_VERSION)
            verdict = ipv4hc_pkg::VERDICT_BAD_VERSION;
        else if (summary.ihl < ipv4hc_pkg::MIN_IHL)
            verdict = ipv4hc_pkg::VERDICT_SHORT_HDR;
        else if (short_pkt)
            verdict = ipv4hc_pkg::VERDICT_TRUNCATED;
        else if (summary.sum != ipv4hc_pkg::SUM_GOOD)
            verdict = ipv4hc_pkg::VERDICT_BAD_CSUM;
        else if (summary.overflow || summary.count != summary.length)
            verdict = ipv4hc_pkg::VERDICT_BAD_LENGTH;
        else if (summary.protocol == accepted_protocol && handler_bound)
            verdict = ipv4hc_pkg::VERDICT_FORWARD;
        else
            verdict = ipv4hc_pkg::VERDICT_UNHANDLED;
    end

    always_comb
    begin
        res_next.verdict             = verdict;
        res_next.protocol_number     = summary.protocol;
        res_next.source_address      = summary.src;
        res_next.destination_address = summary.dst;
        res_next.header_bytes        = hdr_bytes;
        res_next.payload_bytes       = short_pkt ? 16'd0 : summary.count - hdr16;
    end

    // load when the result register is free or is being drained
    assign summary_pop = summary_valid && (!res_valid_reg || pop);
    assign empty       = !res_valid_reg;
    assign result      = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (summary_pop)
            res_valid_reg <= 1'b1;
        else if (pop)
            res_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (summary_pop)
            res_reg <= res_next;
    end

endmodule

`default_nettype wire

// File: rtl/core/ipv4_header_checker.sv
// top level of the ipv4 inbound header checker
`timescale 1ns / 1ps
`default_nettype none

// channel   handshake                 payload
// -------   ---------------------     ------------------------------------
// item      push / full               ipv4hc_pkg::in_item_t, one packet byte
// result    pop / empty               ipv4hc_pkg::out_item_t, one per packet
// config    apb psel/penable/pready   handler_bound (0x0), accepted_protocol (0x4)
//
// one byte transaction per cycle is taken while full is low; the front updates
// its running sum and captured fields in that same cycle
// a packet's record is written to the record queue as its last byte is taken;
// its verdict loads into the result register when that is free or draining
// the record queue between front and back (SUMMARY_DEPTH entries) raises full
// only when the result side has stalled long enough to fill it
// reset clears all per-packet state and sets accepted_protocol to 1 (icmp)

module ipv4_header_checker #(
    parameter int SUMMARY_DEPTH = 2
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    // byte input
    input  wire logic                   push,
    output logic                        full,
    input  wire ipv4hc_pkg::in_item_t   item,
    // verdict output
    output logic                        empty,
    input  wire logic                   pop,
    output ipv4hc_pkg::out_item_t       result,
    // configuration
    input  wire logic                   psel,
    input  wire logic                   penable,
    input  wire logic                   pwrite,
    input  wire logic [2:0]             paddr,
    input  wire logic [31:0]            pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    // configuration registers
    logic       handler_bound_reg;
    logic [7:0] accepted_protocol_reg;
    logic       cfg_write;
    logic       reg_index;

    // front to queue to back
    logic                 take;
    logic                 summary_push;
    ipv4hc_pkg::summary_t front_summary;
    ipv4hc_pkg::summary_t queued_summary;
    logic                 summary_valid;
    logic                 summary_pop;

    assign pready    = 1'b1;
    assign reg_index = paddr[2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            handler_bound_reg     <= 1'b0;
            accepted_protocol_reg <= 8'd1;
        end
        else if (cfg_write)
        begin
            unique case (reg_index)
                ipv4hc_pkg::REG_HANDLER_BOUND:     handler_bound_reg     <= pwdata[0];
                ipv4hc_pkg::REG_ACCEPTED_PROTOCOL: accepted_protocol_reg <= pwdata[7:0];
                default:                           handler_bound_reg     <= handler_bound_reg;
            endcase
        end
    end

    // register readback
    always_comb
    begin
        unique case (reg_index)
            ipv4hc_pkg::REG_HANDLER_BOUND:     prdata = {31'd0, handler_bound_reg};
            ipv4hc_pkg::REG_ACCEPTED_PROTOCOL: prdata = {24'd0, accepted_protocol_reg};
            default:                           prdata = '0;
        endcase
    end

    // a byte is taken whenever the record queue has room
    assign take = push && !full;

    ipv4hc_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .take         (take),
        .item         (item),
        .summary_push (summary_push),
        .summary      (front_summary)
    );

    ipv4hc_sum_fifo #(
        .DEPTH (SUMMARY_DEPTH)
    ) u_sum_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (summary_push),
        .wr_data   (front_summary),
        .rd_en     (summary_pop),
        .rd_data   (queued_summary),
        .full      (full),
        .not_empty (summary_valid)
    );

    // back end: verdict order and payload length, then the result register
    ipv4hc_back u_back (
        .clk               (clk),
        .rst_n             (rst_n),
        .summary_valid     (summary_valid),
        .summary           (queued_summary),
        .summary_pop       (summary_pop),
        .handler_bound     (handler_bound_reg),
        .accepted_protocol (accepted_protocol_reg),
        .result            (result),
        .empty             (empty),
        .pop               (pop)
    );

endmodule

`default_nettype wire

// File: tb/tb_ipv4_header_checker.sv
// self-checking testbench of the ipv4 inbound header checker
`timescale 1ns / 1ps

// Packets go in one byte per transaction on the push/full side. Each
// verdict is checked on the pop/empty side against a bit-accurate model of
// the checker kept in this file.
//
// the run in order:
//   1. both registers are read back at their reset values; then one good icmp
//      packet with the reset configuration, so it must come back unhandled
//   2. a table of directed packets: the extremes of every field, each verdict
//      code, the 65535-byte maximum and an overlong packet that saturates the
//      byte count
//   3. random packets under several configurations, the extremes among them
//
// Both sides insert random idle gaps. Some packets are sent with no gaps on
// either side.

module tb_ipv4_header_checker;

    import ipv4hc_pkg::*;

    // one packet to build and send
    typedef struct {
        logic [3:0]  version;
        logic [3:0]  ihl;
        logic [7:0]  proto;
        logic [31:0] src;
        logic [31:0] dst;
        int          payload;    // bytes after the header
        int          cut;        // if nonzero, only this many bytes are sent
        int          len_delta;  // added to the true total length in the header
        bit          bad_sum;    // corrupt one header bit after the checksum is set
        bit          noise;      // random bytes with no header structure
        int          want;       // verdict typed in by hand, -1 for none
    } recipe_t;

    logic        clk;
    logic        rst_n;
    logic        push;
    logic        full;
    in_item_t    item;
    logic        empty;
    logic        pop;
    out_item_t   result;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // model state of the checker
    logic        cfg_bound;
    logic [7:0]  cfg_proto;
    logic [15:0] pk_count;
    logic [15:0] pk_sum;
    logic [7:0]  pk_hold;
    logic [3:0]  pk_version;
    logic [3:0]  pk_ihl;
    logic [15:0] pk_length;
    logic [7:0]  pk_proto;
    logic [31:0] pk_src;
    logic [31:0] pk_dst;
    logic        pk_ovf;

    out_item_t   pending_verdicts[$];  // expected result transactions, oldest first
    int          typed_verdicts[$];    // hand-typed verdict per packet, -1 for none
    logic [7:0]  frame[$];             // bytes of the packet being sent
    recipe_t     plan[$];              // directed packet table
    int          mismatch_count;
    bit          calm;                 // no idle gaps on either side while set

    ipv4_header_checker dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .item    (item),
        .empty   (empty),
        .pop     (pop),
        .result  (result),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial clk = 1'b0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // hard stop in case a handshake never completes
    initial
    begin
        #30_000_000;
        $display("== FAIL ==");
        $finish;
    end

    task automatic note_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        mismatch_count++;
    endtask

    task automatic clear_packet();
        pk_count   = '0;
        pk_sum     = '0;
        pk_hold    = '0;
        pk_version = '0;
        pk_ihl     = '0;
        pk_length  = '0;
        pk_proto   = '0;
        pk_src     = '0;
        pk_dst     = '0;
        pk_ovf     = 1'b0;
    endtask

    // folds one accepted byte into the model; the last byte of a packet
    // queues the verdict that the checker must give
    task automatic predict_verdict(input logic [7:0] b, input logic last);
        int          pos;
        logic [16:0] wide;
        logic [15:0] hdr;
        out_item_t   r;
        pos = int'(pk_count);
        // fields sit at fixed offsets whatever the ihl says
        if (pos == 0)
        begin
            pk_version = b[7:4];
            pk_ihl     = b[3:0];
        end
        else if (pos == 2)
            pk_length[15:8] = b;
        else if (pos == 3)
            pk_length[7:0] = b;
        else if (pos == 9)
            pk_proto = b;
        else if (pos >= 12 && pos < 16)
            pk_src[(15 - pos) * 8 +: 8] = b;
        else if (pos >= 16 && pos < 20)
            pk_dst[(19 - pos) * 8 +: 8] = b;
        // only bytes inside the header span enter the ones-complement sum
        if (pos < pk_ihl * 4)
        begin
            if (!pos[0])
                pk_hold = b;
            else
            begin
                wide   = {1'b0, pk_sum} + {1'b0, pk_hold, b};
                pk_sum = wide[15:0] + {15'd0, wide[16]};
            end
        end
        // byte count saturates, the flag remembers any byte past it
        if (pk_count == 16'hFFFF)
            pk_ovf = 1'b1;
        else
            pk_count++;
        if (last)
        begin
            hdr = {10'd0, pk_ihl, 2'b00};
            if (pk_version != IP_VERSION)
                r.verdict = VERDICT_BAD_VERSION;
            else if (pk_ihl < MIN_IHL)
                r.verdict = VERDICT_SHORT_HDR;
            else if (pk_count < hdr)
                r.verdict = VERDICT_TRUNCATED;
            else if (pk_sum != SUM_GOOD)
                r.verdict = VERDICT_BAD_CSUM;
            else if (pk_ovf || pk_count != pk_length)
                r.verdict = VERDICT_BAD_LENGTH;
            else if (pk_proto == cfg_proto && cfg_bound)
                r.verdict = VERDICT_FORWARD;
            else
                r.verdict = VERDICT_UNHANDLED;
            r.protocol_number     = pk_proto;
            r.source_address      = pk_src;
            r.destination_address = pk_dst;
            r.header_bytes        = hdr[5:0];
            r.payload_bytes       = (pk_count >= hdr) ? pk_count - hdr : 16'd0;
            pending_verdicts.push_back(r);
            clear_packet();
        end
    endtask

    // mostly no gap, sometimes a short one, rarely a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 25);
    endfunction

    function automatic recipe_t recipe(input logic [3:0] version, input logic [3:0] ihl,
                                       input logic [7:0] proto, input logic [31:0] src,
                                       input logic [31:0] dst, input int payload,
                                       input int cut, input int len_delta,
                                       input bit bad_sum, input int want);
        recipe_t r;
        r.version   = version;
        r.ihl       = ihl;
        r.proto     = proto;
        r.src       = src;
        r.dst       = dst;
        r.payload   = payload;
        r.cut       = cut;
        r.len_delta = len_delta;
        r.bad_sum   = bad_sum;
        r.noise     = 1'b0;
        r.want      = want;
        return r;
    endfunction

    // mostly well-formed packets, some with one defect, some pure noise
    function automatic recipe_t random_recipe();
        recipe_t r;
        int      pick;
        pick = $urandom_range(0, 99);
        r = recipe(IP_VERSION, MIN_IHL, cfg_proto, $urandom, $urandom,
                   $urandom_range(0, 10), 0, 0, 1'b0, -1);
        if ($urandom_range(0, 3) == 0)
            r.ihl = 4'($urandom_range(5, 15));
        if ($urandom_range(0, 1) == 0)
            r.proto = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 19) == 0)
            r.payload = $urandom_range(20, 80);
        if (pick < 8)
            r.bad_sum = 1'b1;
        else if (pick < 14)
            r.len_delta = $urandom_range(0, 1) ? int'($urandom_range(1, 3))
                                               : -int'($urandom_range(1, 3));
        else if (pick < 18)
            r.cut = $urandom_range(1, r.ihl * 4 - 1);
        else if (pick < 21)
            r.version = 4'($urandom_range(0, 15));
        else if (pick < 24)
            r.ihl = 4'($urandom_range(0, 4));
        else if (pick < 32)
            r.noise = 1'b1;
        return r;
    endfunction

    // fills frame with the bytes of one packet
    task automatic build_frame(input recipe_t r);
        int          hlen;
        int          total;
        int          i;
        logic [7:0]  b;
        logic [15:0] acc;
        logic [16:0] wide;
        logic [15:0] lenf;
        frame.delete();
        if (r.noise)
        begin
            total = $urandom_range(1, 30);
            for (i = 0; i < total; i++)
            begin
                b = 8'($urandom_range(0, 255));
                frame.push_back(b);
            end
            return;
        end
        // a short ihl still gets a full 20-byte header so every field exists
        hlen  = (r.ihl < MIN_IHL) ? 20 : r.ihl * 4;
        total = hlen + r.payload;
        for (i = 0; i < total; i++)
        begin
            b = 8'($urandom_range(0, 255));
            frame.push_back(b);
        end
        lenf     = 16'(total + r.len_delta);
        frame[0] = {r.version, r.ihl};
        frame[2] = lenf[15:8];
        frame[3] = lenf[7:0];
        frame[9] = r.proto;
        for (i = 0; i < 4; i++)
        begin
            frame[12 + i] = r.src[31 - 8 * i -: 8];
            frame[16 + i] = r.dst[31 - 8 * i -: 8];
        end
        // header checksum: complement of the sum with the checksum field zero
        frame[10] = 8'h00;
        frame[11] = 8'h00;
        acc = '0;
        for (i = 0; i < hlen; i += 2)
        begin
            wide = {1'b0, acc} + {1'b0, frame[i], frame[i + 1]};
            acc  = wide[15:0] + {15'd0, wide[16]};
        end
        acc       = ~acc;
        frame[10] = acc[15:8];
        frame[11] = acc[7:0];
        if (r.bad_sum)
            frame[4] = frame[4] ^ (8'h01 << $urandom_range(0, 7));
        if (r.cut > 0)
            while (frame.size() > r.cut)
                void'(frame.pop_back());
    endtask

    // one byte transaction; returns at the edge that accepts it, push still high
    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push <= 1'b1;
        item <= '{packet_byte: b, last_byte: last};
        do @(posedge clk); while (full);
    endtask

    task automatic send_frame(input recipe_t r);
        int i;
        build_frame(r);
        typed_verdicts.push_back(r.want);
        for (i = 0; i < frame.size(); i++)
            send_byte(frame[i], i == frame.size() - 1);
    endtask

    // stop sending and wait until every verdict is back and the back end is quiet
    task automatic wait_idle();
        push <= 1'b0;
        @(posedge clk);
        while (pending_verdicts.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // apb read with a check of the value, then the bus is left idle
    task automatic check_reg(input logic idx, input logic [31:0] want);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata !== want)
            note_mismatch("register readback", prdata, want);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // apb write, then read back what was written
    task automatic write_reg(input logic idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (idx == REG_HANDLER_BOUND)
            cfg_bound = val[0];
        else
            cfg_proto = val[7:0];
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        if (idx == REG_HANDLER_BOUND)
            check_reg(idx, {31'd0, cfg_bound});
        else
            check_reg(idx, {24'd0, cfg_proto});
    endtask

    // result side: random stalls, pop held high through bursts
    initial
    begin
        int n;
        pop = 1'b0;
        forever
        begin
            n = pick_gap();
            if (n > 0)
            begin
                pop <= 1'b0;
                repeat (n) @(posedge clk);
            end
            pop <= 1'b1;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    end

    // transaction monitor: values seen here are the ones before the edge
    always @(posedge clk)
    begin
        out_item_t want;
        int        typed;
        if (rst_n)
        begin
            // result first: a byte taken at this edge cannot have its verdict out yet
            if (pop && !empty)
            begin
                if (pending_verdicts.size() == 0)
                    note_mismatch("result with none expected", 32'(result.verdict), 32'd0);
                else
                begin
                    want = pending_verdicts.pop_front();
                    if (result.verdict !== want.verdict)
                        note_mismatch("verdict", 32'(result.verdict), 32'(want.verdict));
                    if (result.protocol_number !== want.protocol_number)
                        note_mismatch("protocol_number", 32'(result.protocol_number),
                                      32'(want.protocol_number));
                    if (result.source_address !== want.source_address)
                        note_mismatch("source_address", result.source_address,
                                      want.source_address);
                    if (result.destination_address !== want.destination_address)
                        note_mismatch("destination_address", result.destination_address,
                                      want.destination_address);
                    if (result.header_bytes !== want.header_bytes)
                        note_mismatch("header_bytes", 32'(result.header_bytes),
                                      32'(want.header_bytes));
                    if (result.payload_bytes !== want.payload_bytes)
                        note_mismatch("payload_bytes", 32'(result.payload_bytes),
                                      32'(want.payload_bytes));
                    if (typed_verdicts.size() != 0)
                    begin
                        typed = typed_verdicts.pop_front();
                        if (typed >= 0 && result.verdict !== typed[2:0])
                            note_mismatch("typed verdict", 32'(result.verdict), typed);
                    end
                end
            end
            if (push && !full)
                predict_verdict(item.packet_byte, item.last_byte);
        end
    end

    initial
    begin
        recipe_t     r;
        int          i;
        int          bytes_sent;
        int          packets_sent;
        int          phase;
        logic        nb;
        logic [7:0]  np;

        push           = 1'b0;
        item           = '0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        rst_n          = 1'b0;
        calm           = 1'b0;
        mismatch_count = 0;
        cfg_bound      = 1'b0;
        cfg_proto      = 8'd1;
        clear_packet();

        // directed table; the first row runs with the reset configuration
        plan.push_back(recipe(4, 5, 1, 32'hC0A80001, 32'h0A000001, 8, 0, 0, 0,
                              VERDICT_UNHANDLED));
        plan.push_back(recipe(4, 5, 1, 32'hC0A80001, 32'h0A000001, 0, 0, 0, 0,
                              VERDICT_FORWARD));
        plan.push_back(recipe(4, 15, 1, 32'h0, 32'h0, 4, 0, 0, 0, VERDICT_FORWARD));
        plan.push_back(recipe(4, 5, 1, 32'hFFFFFFFF, 32'hFFFFFFFF, 3, 0, 0, 0,
                              VERDICT_FORWARD));
        plan.push_back(recipe(6, 5, 1, 32'h01020304, 32'h05060708, 2, 0, 0, 0,
                              VERDICT_BAD_VERSION));
        plan.push_back(recipe(0, 0, 1, 32'h0, 32'h0, 0, 0, 0, 0, VERDICT_BAD_VERSION));
        plan.push_back(recipe(15, 15, 255, 32'hFFFFFFFF, 32'hFFFFFFFF, 0, 0, 0, 0,
                              VERDICT_BAD_VERSION));
        plan.push_back(recipe(4, 4, 1, 32'h0A0A0A0A, 32'h0B0B0B0B, 2, 0, 0, 0,
                              VERDICT_SHORT_HDR));
        plan.push_back(recipe(4, 0, 1, 32'h0A0A0A0A, 32'h0B0B0B0B, 0, 0, 0, 0,
                              VERDICT_SHORT_HDR));
        plan.push_back(recipe(4, 5, 1, 32'h11223344, 32'h55667788, 0, 19, 0, 0,
                              VERDICT_TRUNCATED));
        plan.push_back(recipe(4, 15, 1, 32'h11223344, 32'h55667788, 0, 40, 0, 0,
                              VERDICT_TRUNCATED));
        plan.push_back(recipe(4, 5, 1, 32'h0, 32'h0, 0, 1, 0, 0, VERDICT_TRUNCATED));
        plan.push_back(recipe(4, 5, 1, 32'hAC100001, 32'hAC100002, 6, 0, 0, 1,
                              VERDICT_BAD_CSUM));
        plan.push_back(recipe(4, 5, 1, 32'hAC100001, 32'hAC100002, 6, 0, 1, 0,
                              VERDICT_BAD_LENGTH));
        plan.push_back(recipe(4, 6, 1, 32'hAC100001, 32'hAC100002, 6, 0, -1, 0,
                              VERDICT_BAD_LENGTH));
        plan.push_back(recipe(4, 5, 6, 32'hAC100001, 32'hAC100002, 5, 0, 0, 0,
                              VERDICT_UNHANDLED));
        plan.push_back(recipe(4, 5, 255, 32'hFFFFFFFF, 32'h0, 1, 0, 0, 0,
                              VERDICT_UNHANDLED));
        plan.push_back(recipe(4, 5, 0, 32'h0, 32'hFFFFFFFF, 1, 0, 0, 0,
                              VERDICT_UNHANDLED));
        // largest legal packet, then one that runs past the byte counter
        plan.push_back(recipe(4, 5, 1, 32'hC0000201, 32'hC0000202, 65515, 0, 0, 0,
                              VERDICT_FORWARD));
        plan.push_back(recipe(4, 5, 1, 32'hC0000201, 32'hC0000202, 65517, 0, -2, 0,
                              VERDICT_BAD_LENGTH));

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset configuration: nothing bound, so a good packet is unhandled
        check_reg(REG_HANDLER_BOUND, 32'd0);
        check_reg(REG_ACCEPTED_PROTOCOL, 32'd1);
        send_frame(plan[0]);
        wait_idle();

        write_reg(REG_HANDLER_BOUND, 32'd1);
        write_reg(REG_ACCEPTED_PROTOCOL, 32'd1);
        for (i = 1; i < plan.size(); i++)
        begin
            // the long packets go through with no gaps
            calm = (plan[i].payload > 1000);
            send_frame(plan[i]);
        end
        calm = 1'b0;

        // random packets; the configuration changes every eight packets
        bytes_sent   = 0;
        packets_sent = 0;
        phase        = 0;
        while (bytes_sent < 700 || packets_sent < 40)
        begin
            if (packets_sent % 8 == 0)
            begin
                wait_idle();
                case (phase)
                    0:
                    begin
                        nb = 1'b0;
                        np = 8'd0;
                    end
                    1:
                    begin
                        nb = 1'b1;
                        np = 8'd255;
                    end
                    2:
                    begin
                        nb = 1'b1;
                        np = 8'd0;
                    end
                    default:
                    begin
                        nb = 1'($urandom_range(0, 1));
                        np = ($urandom_range(0, 2) == 0) ? 8'd1 : 8'($urandom_range(0, 255));
                    end
                endcase
                write_reg(REG_HANDLER_BOUND, {31'd0, nb});
                write_reg(REG_ACCEPTED_PROTOCOL, {24'd0, np});
                phase++;
            end
            calm = ($urandom_range(0, 4) == 0);
            r = random_recipe();
            send_frame(r);
            bytes_sent += frame.size();
            packets_sent++;
        end
        calm = 1'b0;

        // drain, then let the back end run on to catch any stray results
        wait_idle();
        repeat (8) @(posedge clk);
        if (mismatch_count == 0 && pending_verdicts.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// File: sim.f
rtl/core/ipv4hc_pkg.sv
rtl/core/ipv4hc_front.sv
rtl/core/ipv4hc_sum_fifo.sv
rtl/core/ipv4hc_back.sv
rtl/core/ipv4_header_checker.sv
tb/tb_ipv4_header_checker.sv
